FILE: src/obmb_pkg.sv
// shared constants and types for the order book minute bar builder
package obmb_pkg;

   localparam int TIME_W   = 32;
   localparam int PRICE_W  = 31;
   localparam int MID_W    = PRICE_W + 1;
   localparam int MINUTE_W = 27;
   localparam int COUNT_W  = 32;
   localparam int SEC_W    = 6;

   localparam int SECONDS_PER_MINUTE = 60;
   localparam logic [SEC_W-1:0] CAPTURE_RESET = SEC_W'(3);

   // time / 60 = (time >> 2) / 15, done as a multiply by ceil(2^34 / 15)
   localparam int DIV_PRE_SHIFT = 2;
   localparam int DIV_SHIFT     = 34;
   localparam int QUOT_IN_W     = TIME_W - DIV_PRE_SHIFT;
   localparam int MAGIC_W       = 31;
   localparam int PROD_W        = QUOT_IN_W + MAGIC_W;
   localparam logic [MAGIC_W-1:0] DIV_MAGIC = MAGIC_W'(1145324613);

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [MINUTE_W-1:0] bar_minute;
      logic [COUNT_W-1:0]  first_index;
      logic [COUNT_W-1:0]  snapshot_count;
      logic [MID_W-1:0]    open_mid2;
      logic [MID_W-1:0]    close_mid2;
      logic [MID_W-1:0]    low_mid2;
      logic [MID_W-1:0]    high_mid2;
      logic [PRICE_W-1:0]  lowest_deep_bid;
      logic [PRICE_W-1:0]  highest_deep_ask;
      logic [PRICE_W-1:0]  captured_bid;
      logic [PRICE_W-1:0]  captured_ask;
   } bar_type;

endpackage

FILE: src/obmb_req_if.sv
// snapshot channel interface
interface obmb_req_if;
   logic                          valid;
   logic                          ready;
   logic [obmb_pkg::TIME_W-1:0]   snapshot_time;
   logic [obmb_pkg::PRICE_W-1:0]  best_bid;
   logic [obmb_pkg::PRICE_W-1:0]  best_ask;
   logic [obmb_pkg::PRICE_W-1:0]  deepest_bid;
   logic [obmb_pkg::PRICE_W-1:0]  deepest_ask;

   modport source (output valid, snapshot_time, best_bid, best_ask, deepest_bid, deepest_ask,
                   input ready);
   modport sink (input valid, snapshot_time, best_bid, best_ask, deepest_bid, deepest_ask,
                 output ready);
endinterface

FILE: src/obmb_rsp_if.sv
// minute bar channel interface
interface obmb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [obmb_pkg::MINUTE_W-1:0]  bar_minute;
   logic [obmb_pkg::COUNT_W-1:0]   first_index;
   logic [obmb_pkg::COUNT_W-1:0]   snapshot_count;
   logic [obmb_pkg::MID_W-1:0]     open_mid2;
   logic [obmb_pkg::MID_W-1:0]     close_mid2;
   logic [obmb_pkg::MID_W-1:0]     low_mid2;
   logic [obmb_pkg::MID_W-1:0]     high_mid2;
   logic [obmb_pkg::PRICE_W-1:0]   lowest_deep_bid;
   logic [obmb_pkg::PRICE_W-1:0]   highest_deep_ask;
   logic [obmb_pkg::PRICE_W-1:0]   captured_bid;
   logic [obmb_pkg::PRICE_W-1:0]   captured_ask;

   modport source (output valid, bar_minute, first_index, snapshot_count, open_mid2,
                   close_mid2, low_mid2, high_mid2, lowest_deep_bid, highest_deep_ask,
                   captured_bid, captured_ask,
                   input ready);
   modport sink (input valid, bar_minute, first_index, snapshot_count, open_mid2,
                 close_mid2, low_mid2, high_mid2, lowest_deep_bid, highest_deep_ask,
                 captured_bid, captured_ask,
                 output ready);
endinterface

FILE: src/order_book_minute_bar_builder.sv
// order book minute bar builder: three-register pipeline with open bar state
// a closed bar enters the output register as the transaction that closes it leaves stage 2
// throughput: one snapshot per cycle unless stage 2 stalls; stage 1 holds the reciprocal
// multiply for the minute, stage 2 the bar update, stage 3 the output register
// stage 2 stalls only when it must emit a bar while the output register is full and not read
// reset: synchronous, clears pipeline valids, open bar flag and total count, capture second to 3
module order_book_minute_bar_builder (
   input  logic                          clock,
   input  logic                          reset,
   obmb_req_if.sink                      req_bus,
   obmb_rsp_if.source                    rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [obmb_pkg::SEC_W-1:0]    csr_wr_data
);

   logic [obmb_pkg::SEC_W-1:0]    capture_ff;

   // stage 1
   logic                          s1_valid_ff;
   logic [obmb_pkg::TIME_W-1:0]   s1_time_ff;
   logic [obmb_pkg::PRICE_W-1:0]  s1_bid_ff;
   logic [obmb_pkg::PRICE_W-1:0]  s1_ask_ff;
   logic [obmb_pkg::PRICE_W-1:0]  s1_deep_bid_ff;
   logic [obmb_pkg::PRICE_W-1:0]  s1_deep_ask_ff;
   logic [obmb_pkg::PROD_W-1:0]   s1_prod_in;
   logic [obmb_pkg::MID_W-1:0]    s1_mid2_in;

   // stage 2
   logic                          s2_valid_ff;
   logic [obmb_pkg::TIME_W-1:0]   s2_time_ff;
   logic [obmb_pkg::MINUTE_W-1:0] s2_minute_ff;
   logic [obmb_pkg::MID_W-1:0]    s2_mid2_ff;
   logic [obmb_pkg::PRICE_W-1:0]  s2_bid_ff;
   logic [obmb_pkg::PRICE_W-1:0]  s2_ask_ff;
   logic [obmb_pkg::PRICE_W-1:0]  s2_deep_bid_ff;
   logic [obmb_pkg::PRICE_W-1:0]  s2_deep_ask_ff;
   logic [obmb_pkg::SEC_W-1:0]    s2_minute_x60_in;
   logic [obmb_pkg::SEC_W-1:0]    s2_sec_in;

   // open bar state
   logic                          have_ff;
   logic [obmb_pkg::TIME_W-1:0]   last_time_ff;
   logic [obmb_pkg::COUNT_W-1:0]  total_ff;
   obmb_pkg::bar_type             bar_ff;

   // output register
   logic                          rsp_valid_ff;
   obmb_pkg::bar_type             rsp_ff;

   logic                          out_free;
   logic                          fresh;
   logic                          same_minute;
   logic                          emit;
   logic                          s2_go;
   logic                          s2_open;
   logic                          s1_open;
   logic [obmb_pkg::COUNT_W-1:0]  total_inc_in;
   logic [obmb_pkg::COUNT_W-1:0]  count_inc_in;

   assign s1_prod_in =
      obmb_pkg::PROD_W'(s1_time_ff[obmb_pkg::TIME_W-1:obmb_pkg::DIV_PRE_SHIFT])
      * obmb_pkg::PROD_W'(obmb_pkg::DIV_MAGIC);
   assign s1_mid2_in = {1'b0, s1_bid_ff} + {1'b0, s1_ask_ff};

   // only the low bits of minute * 60 matter for the second
   assign s2_minute_x60_in = s2_minute_ff[obmb_pkg::SEC_W-1:0]
                             * obmb_pkg::SEC_W'(obmb_pkg::SECONDS_PER_MINUTE);
   assign s2_sec_in        = s2_time_ff[obmb_pkg::SEC_W-1:0] - s2_minute_x60_in;

   assign out_free    = !rsp_valid_ff || rsp_bus.ready;
   assign fresh       = !have_ff || (s2_time_ff > last_time_ff);
   assign same_minute = have_ff && (s2_minute_ff == bar_ff.bar_minute);
   assign emit        = s2_valid_ff && fresh && have_ff && !same_minute;
   assign s2_go       = s2_valid_ff && (!emit || out_free);
   assign s2_open     = !s2_valid_ff || s2_go;
   assign s1_open     = !s1_valid_ff || s2_open;
   assign req_bus.ready = s1_open;

   assign total_inc_in = (total_ff == obmb_pkg::COUNT_MAX) ? total_ff :
                         total_ff + obmb_pkg::COUNT_W'(1);
   assign count_inc_in = (bar_ff.snapshot_count == obmb_pkg::COUNT_MAX) ?
                         bar_ff.snapshot_count :
                         bar_ff.snapshot_count + obmb_pkg::COUNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         capture_ff <= obmb_pkg::CAPTURE_RESET;
      end else if (csr_wr_en) begin
         capture_ff <= csr_wr_data;
      end
   end

   // stage 1: take the transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_open) begin
         s1_valid_ff <= req_bus.valid;
      end
      if (s1_open) begin
         s1_time_ff     <= req_bus.snapshot_time;
         s1_bid_ff      <= req_bus.best_bid;
         s1_ask_ff      <= req_bus.best_ask;
         s1_deep_bid_ff <= req_bus.deepest_bid;
         s1_deep_ask_ff <= req_bus.deepest_ask;
      end
   end

   // stage 2: minute and mid
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_open) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_open) begin
         s2_time_ff     <= s1_time_ff;
         s2_minute_ff   <= s1_prod_in[obmb_pkg::DIV_SHIFT +: obmb_pkg::MINUTE_W];
         s2_mid2_ff     <= s1_mid2_in;
         s2_bid_ff      <= s1_bid_ff;
         s2_ask_ff      <= s1_ask_ff;
         s2_deep_bid_ff <= s1_deep_bid_ff;
         s2_deep_ask_ff <= s1_deep_ask_ff;
      end
   end

   // bar update
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff  <= 1'b0;
         total_ff <= '0;
      end else if (s2_go && fresh) begin
         have_ff  <= 1'b1;
         total_ff <= total_inc_in;
      end
      if (s2_go && fresh) begin
         last_time_ff <= s2_time_ff;
         if (same_minute) begin
            if (s2_mid2_ff < bar_ff.low_mid2) begin
               bar_ff.low_mid2 <= s2_mid2_ff;
            end
            if (s2_mid2_ff > bar_ff.high_mid2) begin
               bar_ff.high_mid2 <= s2_mid2_ff;
            end
            if (s2_deep_bid_ff < bar_ff.lowest_deep_bid) begin
               bar_ff.lowest_deep_bid <= s2_deep_bid_ff;
            end
            if (s2_deep_ask_ff > bar_ff.highest_deep_ask) begin
               bar_ff.highest_deep_ask <= s2_deep_ask_ff;
            end
            bar_ff.snapshot_count <= count_inc_in;
            bar_ff.close_mid2     <= s2_mid2_ff;
            if (s2_sec_in == capture_ff) begin
               bar_ff.captured_bid <= s2_bid_ff;
               bar_ff.captured_ask <= s2_ask_ff;
            end
         end else begin
            bar_ff.bar_minute       <= s2_minute_ff;
            bar_ff.first_index      <= total_ff;
            bar_ff.snapshot_count   <= obmb_pkg::COUNT_W'(1);
            bar_ff.open_mid2        <= s2_mid2_ff;
            bar_ff.close_mid2       <= s2_mid2_ff;
            bar_ff.low_mid2         <= s2_mid2_ff;
            bar_ff.high_mid2        <= s2_mid2_ff;
            bar_ff.lowest_deep_bid  <= s2_deep_bid_ff;
            bar_ff.highest_deep_ask <= s2_deep_ask_ff;
            bar_ff.captured_bid     <= s2_bid_ff;
            bar_ff.captured_ask     <= s2_ask_ff;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_go && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s2_go && emit) begin
         rsp_ff <= bar_ff;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.bar_minute       = rsp_ff.bar_minute;
   assign rsp_bus.first_index      = rsp_ff.first_index;
   assign rsp_bus.snapshot_count   = rsp_ff.snapshot_count;
   assign rsp_bus.open_mid2        = rsp_ff.open_mid2;
   assign rsp_bus.close_mid2       = rsp_ff.close_mid2;
   assign rsp_bus.low_mid2         = rsp_ff.low_mid2;
   assign rsp_bus.high_mid2        = rsp_ff.high_mid2;
   assign rsp_bus.lowest_deep_bid  = rsp_ff.lowest_deep_bid;
   assign rsp_bus.highest_deep_ask = rsp_ff.highest_deep_ask;
   assign rsp_bus.captured_bid     = rsp_ff.captured_bid;
   assign rsp_bus.captured_ask     = rsp_ff.captured_ask;

endmodule

FILE: verif/order_book_minute_bar_checker.sv
`timescale 1ns / 100ps
// checker for the minute bar builder: predicts closed bars from snapshots and compares them
module order_book_minute_bar_checker
   import obmb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   obmb_req_if              req_mon,
   obmb_rsp_if              rsp_mon,
   input  logic             csr_wr_en,
   input  logic [SEC_W-1:0] csr_wr_data,
   output int               mismatch_count,
   output int               bars_outstanding,
   output int               bars_compared
);

   logic                 have_snap;
   logic [TIME_W-1:0]    last_t;
   logic [COUNT_W-1:0]   taken_total;
   logic [SEC_W-1:0]     cap_sec;
   bar_type              open_bar;
   bar_type              closed_bars[$];
   int                   fault_total = 0;
   int                   bars_checked = 0;

   task automatic fold_snapshot(input logic [TIME_W-1:0] t, input logic [PRICE_W-1:0] bb,
                                input logic [PRICE_W-1:0] ba, input logic [PRICE_W-1:0] db,
                                input logic [PRICE_W-1:0] da);
      logic [MID_W-1:0]    mid2;
      logic [MINUTE_W-1:0] minute;
      logic [SEC_W-1:0]    sec;
      logic [COUNT_W-1:0]  idx;
      mid2   = {1'b0, bb} + {1'b0, ba};
      minute = MINUTE_W'(t / TIME_W'(SECONDS_PER_MINUTE));
      sec    = SEC_W'(t % TIME_W'(SECONDS_PER_MINUTE));
      if (have_snap && t <= last_t) begin
         return;
      end
      idx = taken_total;
      if (taken_total != COUNT_MAX) begin
         taken_total = taken_total + COUNT_W'(1);
      end
      if (have_snap && minute == open_bar.bar_minute) begin
         if (mid2 < open_bar.low_mid2) open_bar.low_mid2 = mid2;
         if (mid2 > open_bar.high_mid2) open_bar.high_mid2 = mid2;
         if (db < open_bar.lowest_deep_bid) open_bar.lowest_deep_bid = db;
         if (da > open_bar.highest_deep_ask) open_bar.highest_deep_ask = da;
         if (open_bar.snapshot_count != COUNT_MAX) begin
            open_bar.snapshot_count = open_bar.snapshot_count + COUNT_W'(1);
         end
         open_bar.close_mid2 = mid2;
         if (sec == cap_sec) begin
            open_bar.captured_bid = bb;
            open_bar.captured_ask = ba;
         end
      end else begin
         if (have_snap) begin
            closed_bars.insert(closed_bars.size(), open_bar);
         end
         open_bar.bar_minute       = minute;
         open_bar.first_index      = idx;
         open_bar.snapshot_count   = COUNT_W'(1);
         open_bar.open_mid2        = mid2;
         open_bar.close_mid2       = mid2;
         open_bar.low_mid2         = mid2;
         open_bar.high_mid2        = mid2;
         open_bar.lowest_deep_bid  = db;
         open_bar.highest_deep_ask = da;
         open_bar.captured_bid     = bb;
         open_bar.captured_ask     = ba;
      end
      have_snap = 1'b1;
      last_t    = t;
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: bar %0d %s expected %0h actual %0h", $time, bars_checked, field,
                  want, got);
         fault_total++;
      end
   endtask

   always @(posedge clock) begin
      bar_type want;
      if (reset) begin
         have_snap   = 1'b0;
         last_t      = '0;
         taken_total = '0;
         cap_sec     = CAPTURE_RESET;
         open_bar    = '0;
         closed_bars.delete();
      end else begin
         if (csr_wr_en) begin
            cap_sec = csr_wr_data;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (closed_bars.size() == 0) begin
               $display("%0t: unexpected bar, expected none, actual minute %0h", $time,
                        rsp_mon.bar_minute);
               fault_total++;
            end else begin
               want = closed_bars.pop_front();
               compare_field("bar_minute", 32'(want.bar_minute), 32'(rsp_mon.bar_minute));
               compare_field("first_index", want.first_index, rsp_mon.first_index);
               compare_field("snapshot_count", want.snapshot_count, rsp_mon.snapshot_count);
               compare_field("open_mid2", want.open_mid2, rsp_mon.open_mid2);
               compare_field("close_mid2", want.close_mid2, rsp_mon.close_mid2);
               compare_field("low_mid2", want.low_mid2, rsp_mon.low_mid2);
               compare_field("high_mid2", want.high_mid2, rsp_mon.high_mid2);
               compare_field("lowest_deep_bid", 32'(want.lowest_deep_bid),
                             32'(rsp_mon.lowest_deep_bid));
               compare_field("highest_deep_ask", 32'(want.highest_deep_ask),
                             32'(rsp_mon.highest_deep_ask));
               compare_field("captured_bid", 32'(want.captured_bid), 32'(rsp_mon.captured_bid));
               compare_field("captured_ask", 32'(want.captured_ask), 32'(rsp_mon.captured_ask));
               bars_checked++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            fold_snapshot(req_mon.snapshot_time, req_mon.best_bid, req_mon.best_ask,
                          req_mon.deepest_bid, req_mon.deepest_ask);
         end
      end
      mismatch_count   <= fault_total;
      bars_outstanding <= closed_bars.size();
      bars_compared    <= bars_checked;
   end

endmodule

FILE: verif/order_book_minute_bar_builder_tb.sv
`timescale 1ns / 100ps
// testbench top for the minute bar builder: clock, reset, snapshot stimulus, stalls, verdict
module order_book_minute_bar_builder_tb;
   import obmb_pkg::*;

   localparam int SNAPSHOT_TARGET = 850;
   localparam int PHASES          = 6;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int SETTLE_CYCLES   = 8;
   localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
   localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
   localparam logic [63:0]        TIME_CEIL = 64'hF000_0000;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [SEC_W-1:0] csr_wr_data;

   obmb_req_if req_bus();
   obmb_rsp_if rsp_bus();

   int mismatches;
   int bars_waiting;
   int bars_matched;

   logic              no_gaps = 1'b0;
   logic              started = 1'b0;
   logic [TIME_W-1:0] last_time_sent = '0;
   logic [SEC_W-1:0]  capture_now = CAPTURE_RESET;
   int                fresh_sent = 0;
   int                stale_sent = 0;
   int                settings_used = 0;
   int                idle_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   order_book_minute_bar_builder dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   order_book_minute_bar_checker bar_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .mismatch_count   (mismatches),
      .bars_outstanding (bars_waiting),
      .bars_compared    (bars_matched)
   );

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [PRICE_W-1:0] pick_price();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return PRICE_MAX;
         2: return PRICE_W'($urandom_range(0, 1000));
         3: return PRICE_MAX - PRICE_W'($urandom_range(0, 1000));
         default: return PRICE_W'($urandom());
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] next_time();
      logic [63:0] base;
      logic [63:0] t;
      int          r;
      base = 64'(last_time_sent);
      r    = $urandom_range(0, 99);
      if (!started) return TIME_W'($urandom_range(0, 200));
      if (r < 8) begin
         return last_time_sent -
                TIME_W'($urandom_range(0, last_time_sent < 100 ? last_time_sent : 100));
      end
      if (r < 18) begin
         t = (base / 60) * 60 + 64'(capture_now);
         if (t <= base) t = t + 60;
      end else if (r < 70) begin
         t = base + $urandom_range(1, 7);
      end else if (r < 88) begin
         t = base + $urandom_range(8, 150);
      end else if (r < 96) begin
         t = base + $urandom_range(151, 20000);
      end else begin
         t = base + $urandom_range(20001, 1 << 22);
      end
      if (t > TIME_CEIL) t = base + 1;
      return TIME_W'(t);
   endfunction

   task automatic send_snapshot(input logic [TIME_W-1:0] t, input logic [PRICE_W-1:0] bb,
                                input logic [PRICE_W-1:0] ba, input logic [PRICE_W-1:0] db,
                                input logic [PRICE_W-1:0] da);
      int gap;
      gap = pick_gap();
      if (started && t <= last_time_sent) begin
         stale_sent++;
      end else begin
         fresh_sent++;
         started        = 1'b1;
         last_time_sent = t;
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.snapshot_time <= t;
      req_bus.best_bid      <= bb;
      req_bus.best_ask      <= ba;
      req_bus.deepest_bid   <= db;
      req_bus.deepest_ask   <= da;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic send_random();
      send_snapshot(next_time(), pick_price(), pick_price(), pick_price(), pick_price());
   endtask

   // wait for all closed bars, then let the pipeline empty
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (bars_waiting != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capture(input logic [SEC_W-1:0] sec);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= sec;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      capture_now = sec;
      settings_used++;
   endtask

   initial begin
      int rsp_hold;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_hold = pick_gap();
         if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("order_book_minute_bar_builder_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      int               phase_start;
      int               iter;
      logic [SEC_W-1:0] phase_cap;
      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_wr_data           <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.snapshot_time <= '0;
      req_bus.best_bid      <= '0;
      req_bus.best_ask      <= '0;
      req_bus.deepest_bid   <= '0;
      req_bus.deepest_ask   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // capture second at its reset value
      send_snapshot(0, '0, '0, '0, '0);
      send_snapshot(0, 5, 6, 7, 8);
      send_snapshot(3, PRICE_MAX, PRICE_MAX, PRICE_MAX, PRICE_MAX);
      send_snapshot(2, 1, 1, 1, 1);
      send_snapshot(59, '0, PRICE_MAX, 100, 200);
      send_snapshot(60, PRICE_MAX, '0, PRICE_MAX, '0);
      send_snapshot(63, 1000, 2000, 50, 60);
      send_snapshot(64, 10, 20, 30, 40);
      send_snapshot(119, PRICE_MAX, 1, 0, PRICE_MAX);
      send_snapshot(240, 77, 88, 99, 111);
      send_snapshot(303, 5, 5, 5, 5);
      send_snapshot(304, 6, 6, 6, 6);
      settle();
      write_capture(0);
      send_snapshot(360, 400, 500, 600, 700);
      send_snapshot(361, 401, 501, 601, 701);
      send_snapshot(420, 1, 2, 3, 4);
      settle();
      write_capture(63);
      send_snapshot(480, 11, 12, 13, 14);
      send_snapshot(483, 21, 22, 23, 24);
      send_snapshot(539, 31, 32, 33, 34);
      send_snapshot(540, 41, 42, 43, 44);
      settle();
      write_capture(59);
      send_snapshot(599, 51, 52, 53, 54);
      send_snapshot(600, 61, 62, 63, 64);
      send_snapshot(659, 71, 72, 73, 74);
      send_snapshot(660, 81, 82, 83, 84);

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: phase_cap = SEC_W'($urandom_range(0, 59));
            1: phase_cap = SEC_W'(60);
            2: phase_cap = CAPTURE_RESET;
            3: phase_cap = '1;
            4: phase_cap = SEC_W'(59);
            default: phase_cap = SEC_W'($urandom_range(0, 63));
         endcase
         write_capture(phase_cap);
         send_snapshot(last_time_sent + TIME_W'($urandom_range(1, 1 << 27)), pick_price(),
                       pick_price(), pick_price(), pick_price());
         phase_start = fresh_sent + stale_sent;
         iter        = 0;
         while (fresh_sent + stale_sent - phase_start < SNAPSHOT_TARGET / PHASES) begin
            if (iter % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            send_random();
            iter++;
         end
      end
      no_gaps = 1'b0;

      // top of the time range: last bars before it, then the newest minute stays open
      send_snapshot(32'd4294967219, pick_price(), pick_price(), pick_price(), pick_price());
      send_snapshot(32'd4294967220, pick_price(), pick_price(), pick_price(), pick_price());
      send_snapshot(32'd4294967280, pick_price(), pick_price(), pick_price(), pick_price());
      send_snapshot(TIME_MAX, pick_price(), pick_price(), pick_price(), pick_price());
      send_snapshot(TIME_MAX, pick_price(), pick_price(), pick_price(), pick_price());
      send_snapshot(5, pick_price(), pick_price(), pick_price(), pick_price());
      settle();

      $display("covered %0d in-order snapshots and %0d stale or repeated ones",
               fresh_sent, stale_sent);
      $display("compared %0d closed minute bars over %0d capture second writes",
               bars_matched, settings_used);
      if (mismatches == 0 && bars_waiting == 0) begin
         $display("order_book_minute_bar_builder_tb OK");
      end else begin
         $display("order_book_minute_bar_builder_tb NOT OK");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/obmb_pkg.sv
src/obmb_req_if.sv
src/obmb_rsp_if.sv
src/order_book_minute_bar_builder.sv
verif/order_book_minute_bar_checker.sv
verif/order_book_minute_bar_builder_tb.sv
